// ----- sv/triangle_barycentric_coordinates_unit_assert.svh -----
// Assertion macros shared by the barycentric coordinates unit.
// Expects i_clk and an active-low synchronous reset i_rst_n in the using module.
`ifndef TRIANGLE_BARYCENTRIC_COORDINATES_UNIT_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_COORDINATES_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TBC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tbc assertion failed");

// Next-cycle implication, checked outside reset.
`define TBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tbc assertion failed");

`endif

// ----- sv/tbc_pkg.sv -----
// Shared types and constants of the barycentric coordinates unit.
// No dependencies.
package tbc_pkg;

    localparam int TBC_COORD_W   = 32;
    localparam int TBC_DIFF_W    = 33;
    localparam int TBC_PROD_W    = 66;
    localparam int TBC_MAG_W     = 65;
    localparam int TBC_SQ_W      = 130;
    localparam int TBC_SUM_W     = 132;
    localparam int TBC_WEIGHT_W  = 18;
    localparam int TBC_REM_W     = 170;
    // Covers the eight beats that are in flight between an accept and the
    // read of the same beat from the middle queue, so input never stalls
    // while the back part keeps reading.
    localparam int TBC_MID_DEPTH = 9;
    localparam int TBC_OUT_DEPTH = 32;

    typedef struct packed {
        logic signed [TBC_COORD_W-1:0] point_x;
        logic signed [TBC_COORD_W-1:0] point_y;
        logic signed [TBC_COORD_W-1:0] point_z;
        logic signed [TBC_COORD_W-1:0] vertex_a_x;
        logic signed [TBC_COORD_W-1:0] vertex_a_y;
        logic signed [TBC_COORD_W-1:0] vertex_a_z;
        logic signed [TBC_COORD_W-1:0] vertex_b_x;
        logic signed [TBC_COORD_W-1:0] vertex_b_y;
        logic signed [TBC_COORD_W-1:0] vertex_b_z;
        logic signed [TBC_COORD_W-1:0] vertex_c_x;
        logic signed [TBC_COORD_W-1:0] vertex_c_y;
        logic signed [TBC_COORD_W-1:0] vertex_c_z;
    } t_tbc_in;

    typedef struct packed {
        logic [TBC_WEIGHT_W-1:0] weight_u;
        logic [TBC_WEIGHT_W-1:0] weight_v;
        logic                    degenerate;
    } t_tbc_out;

    // Squared cross-product lengths of one query.
    typedef struct packed {
        logic [TBC_SUM_W-1:0] s0;
        logic [TBC_SUM_W-1:0] su;
        logic [TBC_SUM_W-1:0] sv;
    } t_tbc_areas;

endpackage

// ----- sv/tbc_fifo.sv -----
// Small register-based FIFO used between the pipeline parts.
// Depends on the assertion macro header only.
`include "triangle_barycentric_coordinates_unit_assert.svh"
module tbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_rd,
    output logic [WIDTH-1:0]           o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH+1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ADDR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == ADDR_W'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == ADDR_W'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_count = r_count;

    `TBC_ASSERT_IMPLIES(a_no_overflow, r_count == CNT_W'(DEPTH), !(i_wr && !i_rd))
    `TBC_ASSERT_IMPLIES(a_no_underflow, i_rd, r_count != '0)
    `TBC_ASSERT_NEXT(a_count_up, i_wr && !i_rd, r_count == $past(r_count) + 1'b1)

endmodule

// ----- sv/tbc_front.sv -----
// Front part: edge differences, cross products and their squared lengths.
// Depends on tbc_pkg.
module tbc_front
    import tbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_tbc_in    i_item,
    output logic       o_valid,
    output t_tbc_areas o_areas
);
    localparam int HALF_W = TBC_COORD_W;
    localparam int HI_W   = TBC_MAG_W - HALF_W;

    logic [6:0] r_vld;

    t_tbc_in                       r_item;
    logic signed [TBC_COORD_W-1:0] w_q [3][3][3];
    logic signed [TBC_DIFF_W-1:0]  r_e [3][3];
    logic signed [TBC_DIFF_W-1:0]  r_f [3][3];
    logic signed [TBC_PROD_W-1:0]  r_p [3][3][2];
    logic [TBC_MAG_W-1:0]          r_m [3][3];
    logic [2*HI_W-1:0]             r_hh [3][3];
    logic [HI_W+HALF_W-1:0]        r_hl [3][3];
    logic [2*HALF_W-1:0]           r_ll [3][3];
    logic [TBC_SQ_W-1:0]           r_sq [3][3];
    logic [TBC_SUM_W-1:0]          r_sum [3];

    // Valid bits travel with the data; this part never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_item <= i_item;
        end
    end

    // Vertex order of the three cross products: (A,B,C), (B,C,P), (C,A,P).
    always_comb begin
        w_q[0][0] = '{r_item.vertex_a_x, r_item.vertex_a_y, r_item.vertex_a_z};
        w_q[0][1] = '{r_item.vertex_b_x, r_item.vertex_b_y, r_item.vertex_b_z};
        w_q[0][2] = '{r_item.vertex_c_x, r_item.vertex_c_y, r_item.vertex_c_z};
        w_q[1][0] = '{r_item.vertex_b_x, r_item.vertex_b_y, r_item.vertex_b_z};
        w_q[1][1] = '{r_item.vertex_c_x, r_item.vertex_c_y, r_item.vertex_c_z};
        w_q[1][2] = '{r_item.point_x, r_item.point_y, r_item.point_z};
        w_q[2][0] = '{r_item.vertex_c_x, r_item.vertex_c_y, r_item.vertex_c_z};
        w_q[2][1] = '{r_item.vertex_a_x, r_item.vertex_a_y, r_item.vertex_a_z};
        w_q[2][2] = '{r_item.point_x, r_item.point_y, r_item.point_z};
    end

    // Edge vectors, exact in 33 bits.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                r_e[k][i] <= {w_q[k][1][i][TBC_COORD_W-1], w_q[k][1][i]}
                           - {w_q[k][0][i][TBC_COORD_W-1], w_q[k][0][i]};
                r_f[k][i] <= {w_q[k][2][i][TBC_COORD_W-1], w_q[k][2][i]}
                           - {w_q[k][0][i][TBC_COORD_W-1], w_q[k][0][i]};
            end
        end
    end

    // Product pairs of each cross-product component.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++) begin
                r_p[k][t][0] <= r_e[k][(t+1)%3] * r_f[k][(t+2)%3];
                r_p[k][t][1] <= r_e[k][(t+2)%3] * r_f[k][(t+1)%3];
            end
        end
    end

    // Component difference and its magnitude.
    always_ff @(posedge i_clk) begin
        logic [TBC_PROD_W:0] v_d;
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++) begin
                v_d = {r_p[k][t][0][TBC_PROD_W-1], r_p[k][t][0]}
                    - {r_p[k][t][1][TBC_PROD_W-1], r_p[k][t][1]};
                if (v_d[TBC_PROD_W]) begin
                    v_d = -v_d;
                end
                r_m[k][t] <= v_d[TBC_MAG_W-1:0];
            end
        end
    end

    // Partial products of each square.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++) begin
                r_hh[k][t] <= r_m[k][t][TBC_MAG_W-1:HALF_W] * r_m[k][t][TBC_MAG_W-1:HALF_W];
                r_hl[k][t] <= r_m[k][t][TBC_MAG_W-1:HALF_W] * r_m[k][t][HALF_W-1:0];
                r_ll[k][t] <= r_m[k][t][HALF_W-1:0] * r_m[k][t][HALF_W-1:0];
            end
        end
    end

    // Assemble the squares.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++) begin
                r_sq[k][t] <= (TBC_SQ_W'(r_hh[k][t]) << (2*HALF_W))
                            + (TBC_SQ_W'(r_hl[k][t]) << (HALF_W+1))
                            + TBC_SQ_W'(r_ll[k][t]);
            end
        end
    end

    // Sum of the three squared components.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sum[k] <= TBC_SUM_W'(r_sq[k][0]) + TBC_SUM_W'(r_sq[k][1])
                      + TBC_SUM_W'(r_sq[k][2]);
        end
    end

    assign o_valid    = r_vld[6];
    assign o_areas.s0 = r_sum[0];
    assign o_areas.su = r_sum[1];
    assign o_areas.sv = r_sum[2];

endmodule

// ----- sv/tbc_back.sv -----
// Back part: pipelined bit-by-bit root of the area ratios, one bit per stage.
// Depends on tbc_pkg.
module tbc_back
    import tbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_tbc_areas i_areas,
    output logic       o_valid,
    output t_tbc_out   o_result
);
    // Partial root state: remainder, root times divisor, and the root bits.
    typedef struct packed {
        logic [TBC_REM_W-1:0]    rem;
        logic [TBC_REM_W-1:0]    acc;
        logic [TBC_WEIGHT_W-1:0] q;
    } t_tbc_lane;

    // Try one root bit: (q+2^b)^2*D - q^2*D = 2^(b+1)*q*D + 2^(2b)*D.
    function automatic t_tbc_lane root_step(t_tbc_lane l, logic [TBC_SUM_W-1:0] d, int b);
        logic [TBC_REM_W-1:0] v_inc;
        logic [TBC_REM_W:0]   v_diff;
        t_tbc_lane            v_out;
        v_inc  = (l.acc << (b + 1)) + (TBC_REM_W'(d) << (2 * b));
        v_diff = {1'b0, l.rem} - {1'b0, v_inc};
        v_out  = l;
        if (!v_diff[TBC_REM_W]) begin
            v_out.rem  = v_diff[TBC_REM_W-1:0];
            v_out.acc  = l.acc + (TBC_REM_W'(d) << b);
            v_out.q[b] = 1'b1;
        end
        return v_out;
    endfunction

    logic [TBC_WEIGHT_W:0] r_vld;
    logic [TBC_SUM_W-1:0]  r_d [TBC_WEIGHT_W+1];
    t_tbc_lane             r_u [TBC_WEIGHT_W+1];
    t_tbc_lane             r_v [TBC_WEIGHT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TBC_WEIGHT_W-1:0], i_valid};
        end
    end

    // Entry stage: remainders start at the numerators scaled by 2^32.
    always_ff @(posedge i_clk) begin
        r_d[0]     <= i_areas.s0;
        r_u[0].rem <= TBC_REM_W'(i_areas.su) << 32;
        r_u[0].acc <= '0;
        r_u[0].q   <= '0;
        r_v[0].rem <= TBC_REM_W'(i_areas.sv) << 32;
        r_v[0].acc <= '0;
        r_v[0].q   <= '0;
    end

    // One stage per root bit, most significant first.
    for (genvar g = 0; g < TBC_WEIGHT_W; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_d[g+1] <= r_d[g];
            r_u[g+1] <= root_step(r_u[g], r_d[g], TBC_WEIGHT_W - 1 - g);
            r_v[g+1] <= root_step(r_v[g], r_d[g], TBC_WEIGHT_W - 1 - g);
        end
    end

    // A zero-area triangle forces both weights to zero.
    always_comb begin
        o_result.degenerate = (r_d[TBC_WEIGHT_W] == '0);
        o_result.weight_u   = o_result.degenerate ? '0 : r_u[TBC_WEIGHT_W].q;
        o_result.weight_v   = o_result.degenerate ? '0 : r_v[TBC_WEIGHT_W].q;
    end

    assign o_valid = r_vld[TBC_WEIGHT_W];

endmodule

// ----- sv/triangle_barycentric_coordinates_unit.sv -----
// Barycentric weights of a point in a triangle by area ratio.
//
// Input channel: queries (point P, vertices A, B, C in signed Q16.16) are
// pushed with push while full is low. Result channel: weight_u, weight_v
// (unsigned Q2.16, saturating) and a degenerate flag are shown while empty
// is low and taken with pop. Results leave in query order.
// A query is accepted every cycle while full is low, so throughput is one item per cycle.
// On its way to the result queue a query passes a 7-stage cross-product
// front part, a one-entry hop through the middle queue, and a 19-stage root
// pipeline (an entry stage, then one weight bit per stage).
// Reset empties both queues and clears the credit counters and valid bits.
// When pop is held low the result queue fills, the back part stops taking
// from the middle queue, and full rises once the middle queue's credit is
// used up; nothing is dropped.
// Depends on tbc_pkg, tbc_front, tbc_back and tbc_fifo.
module triangle_barycentric_coordinates_unit
    import tbc_pkg::*;
#(
    parameter int MID_DEPTH = TBC_MID_DEPTH,
    parameter int OUT_DEPTH = TBC_OUT_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_tbc_in  i_item,
    output logic     empty,
    input  logic     pop,
    output t_tbc_out o_result
);
    localparam int MID_CNT_W = $clog2(MID_DEPTH+1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

    logic                 w_accept;
    logic                 w_front_valid;
    t_tbc_areas           w_front_areas;
    t_tbc_areas           w_mid_areas;
    logic [MID_CNT_W-1:0] w_mid_count;
    logic                 w_mid_rd;
    logic                 w_back_valid;
    t_tbc_out             w_back_result;
    logic [OUT_CNT_W-1:0] w_out_count;
    logic                 w_out_rd;
    logic [MID_CNT_W-1:0] r_front_cred, n_front_cred;
    logic [OUT_CNT_W-1:0] r_back_cred, n_back_cred;

    // Credits cover beats in flight plus beats held in each queue.
    assign full     = (r_front_cred == MID_CNT_W'(MID_DEPTH));
    assign w_accept = push && !full;
    assign w_mid_rd = (w_mid_count != '0) && (r_back_cred != OUT_CNT_W'(OUT_DEPTH));
    assign empty    = (w_out_count == '0);
    assign w_out_rd = pop && !empty;

    always_comb begin
        n_front_cred = r_front_cred + MID_CNT_W'(w_accept) - MID_CNT_W'(w_mid_rd);
        n_back_cred  = r_back_cred + OUT_CNT_W'(w_mid_rd) - OUT_CNT_W'(w_out_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_cred <= '0;
            r_back_cred  <= '0;
        end else begin
            r_front_cred <= n_front_cred;
            r_back_cred  <= n_back_cred;
        end
    end

    tbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (i_item),
        .o_valid (w_front_valid),
        .o_areas (w_front_areas)
    );

    tbc_fifo #(
        .WIDTH ($bits(t_tbc_areas)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_front_valid),
        .i_wdata (w_front_areas),
        .i_rd    (w_mid_rd),
        .o_rdata (w_mid_areas),
        .o_count (w_mid_count)
    );

    tbc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mid_rd),
        .i_areas  (w_mid_areas),
        .o_valid  (w_back_valid),
        .o_result (w_back_result)
    );

    tbc_fifo #(
        .WIDTH ($bits(t_tbc_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_back_valid),
        .i_wdata (w_back_result),
        .i_rd    (w_out_rd),
        .o_rdata (o_result),
        .o_count (w_out_count)
    );

endmodule
